FILE: rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and codes for the duration timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_ADDED = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] elapsed;
    logic [31:0] target;
    logic        periodic;
    logic [7:0]  owner;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [7:0]  fired_owner;
    logic [31:0] accumulated;
    logic        last;
  } out_word_t;

endpackage

FILE: rtl/dtt_queue.sv
// ----------------------------------------------------------------------------
// dtt_queue
// Two-entry word queue between the front and back parts.
// ----------------------------------------------------------------------------
module dtt_queue (
  input  logic              clk,
  input  logic              rst,
  input  dtt_pkg::in_word_t wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output dtt_pkg::in_word_t rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);

  dtt_pkg::in_word_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

FILE: rtl/dtt_engine.sv
// ----------------------------------------------------------------------------
// dtt_engine
// Back part: holds the slot table, runs adds, deletes and the tick scan.
// ----------------------------------------------------------------------------
module dtt_engine #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dtt_pkg::in_word_t  cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output dtt_pkg::out_word_t res,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;
  logic [IW-1:0] scan;
  logic [31:0] elapsed;

  logic [TIMER_SLOTS-1:0] slot_used;
  logic [TIMER_SLOTS-1:0] slot_waiting_join;
  logic [TIMER_SLOTS-1:0] slot_marked_delete;
  logic        slot_periodic    [TIMER_SLOTS];
  logic [31:0] slot_target      [TIMER_SLOTS];
  logic [31:0] slot_accumulated [TIMER_SLOTS];
  logic [15:0] slot_id          [TIMER_SLOTS];
  logic [7:0]  slot_owner       [TIMER_SLOTS];
  logic [15:0] next_timer_id;

  logic                   free_found;
  logic [IW-1:0]          free_idx;
  logic [32:0]            sum_wide;
  logic [31:0]            sum;
  logic                   active;
  logic                   fires;
  logic                   out_free;
  logic [TIMER_SLOTS-1:0] del_hit;
  dtt_pkg::out_word_t     res_next;
  logic                   res_load;
  logic                   res_valid_next;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      del_hit[i] = slot_used[i] && !slot_waiting_join[i] && (slot_owner[i] == cmd.owner);
    end
  end

  assign sum_wide  = {1'b0, slot_accumulated[scan]} + {1'b0, elapsed};
  assign sum       = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
  assign active    = slot_used[scan] && !slot_waiting_join[scan];
  assign fires     = active && (sum >= slot_target[scan]);
  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;

  always_comb begin
    res_next       = '0;
    res_next.kind  = dtt_pkg::KIND_DONE;
    res_next.last  = 1'b1;
    res_load       = 1'b0;
    res_valid_next = res_valid && !res_ready;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free &&
            dtt_pkg::action_t'(cmd.action) != dtt_pkg::ACT_TICK) begin
          res_load       = 1'b1;
          res_valid_next = 1'b1;
          if (dtt_pkg::action_t'(cmd.action) == dtt_pkg::ACT_ADD) begin
            if (free_found) begin
              res_next.kind     = dtt_pkg::KIND_ADDED;
              res_next.timer_id = next_timer_id;
            end else begin
              res_next.kind = dtt_pkg::KIND_FULL;
            end
          end
        end
      end
      ST_SCAN: begin
        if (out_free && fires) begin
          res_load             = 1'b1;
          res_valid_next       = 1'b1;
          res_next.kind        = dtt_pkg::KIND_FIRED;
          res_next.timer_id    = slot_id[scan];
          res_next.fired_owner = slot_owner[scan];
          res_next.accumulated = sum;
          res_next.last        = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_load       = 1'b1;
          res_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      scan               <= '0;
      slot_used          <= '0;
      slot_waiting_join  <= '0;
      slot_marked_delete <= '0;
      next_timer_id      <= '0;
      res_valid          <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (res_load) begin
        res <= res_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && out_free) begin
            unique case (dtt_pkg::action_t'(cmd.action))
              dtt_pkg::ACT_TICK: begin
                elapsed            <= cmd.elapsed;
                slot_used          <= slot_used & ~slot_marked_delete;
                slot_waiting_join  <= slot_waiting_join & ~slot_marked_delete;
                slot_marked_delete <= '0;
                scan               <= '0;
                state              <= ST_SCAN;
              end
              dtt_pkg::ACT_ADD: begin
                if (free_found) begin
                  slot_used[free_idx]          <= 1'b1;
                  slot_waiting_join[free_idx]  <= 1'b1;
                  slot_marked_delete[free_idx] <= 1'b0;
                  slot_periodic[free_idx]      <= cmd.periodic;
                  slot_target[free_idx]        <= cmd.target;
                  slot_accumulated[free_idx]   <= '0;
                  slot_id[free_idx]            <= next_timer_id;
                  slot_owner[free_idx]         <= cmd.owner;
                  next_timer_id                <= next_timer_id + 16'd1;
                end
              end
              dtt_pkg::ACT_DELETE: begin
                slot_marked_delete <= slot_marked_delete | del_hit;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            if (active) begin
              slot_accumulated[scan] <= (fires && slot_periodic[scan]) ? 32'd0 : sum;
            end
            if (fires && !slot_periodic[scan]) begin
              slot_used[scan] <= 1'b0;
            end
            if (32'(scan) == TIMER_SLOTS - 1) begin
              state <= ST_DONE;
            end else begin
              scan <= scan + IW'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            slot_waiting_join <= '0;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/duration_timer_table_core.sv
// ----------------------------------------------------------------------------
// duration_timer_table_core
// Timer table: a queue front end feeding a slot-scan back end.
// ----------------------------------------------------------------------------
// add, delete and no-op: pass the queue entry, then the result register
// tick: one slot per cycle while the output is free, then a done word
// throughput: one add/delete per cycle if out_ready; a tick blocks commands
// reset: synchronous, clears all slots, the queue and the id counter
module duration_timer_table_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dtt_pkg::in_word_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output dtt_pkg::out_word_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);

  dtt_pkg::in_word_t q_data;
  logic              q_valid;
  logic              q_ready;

  dtt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (in_data),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  dtt_engine #(.TIMER_SLOTS(TIMER_SLOTS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_data),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .res       (out_data),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

endmodule
